### src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, codes and sizes for the postfix stack calculator.
// ----------------------------------------------------------------------------
package psc_pkg;

    // Data path and stack sizing
    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 64;                       // 2 .. 127
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_OUT_W = 7;

    // Token queue between front and back (power of two)
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // Divider step count
    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // Token action codes
    typedef enum logic [2:0] {
        ACT_PUSH    = 3'd0,
        ACT_ADD     = 3'd1,
        ACT_SUB     = 3'd2,
        ACT_REM     = 3'd3,
        ACT_MUL     = 3'd4,
        ACT_DIV     = 3'd5,
        ACT_UNKNOWN = 3'd6,
        ACT_FINISH  = 3'd7
    } t_action;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // Token class assigned by the front end
    typedef enum logic [1:0] {
        K_PUSH    = 2'd0,
        K_ARITH   = 2'd1,
        K_UNKNOWN = 2'd2,
        K_FINISH  = 2'd3
    } t_kind;

    // Classified token as queued for the back end
    typedef struct packed {
        t_kind              kind;
        t_action            op;
        logic [DATA_W-1:0]  operand;
    } t_tok;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic               want_rem;
        logic [DATA_W-1:0]  dividend;
        logic [DATA_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DATA_W-1:0]  result;
    } t_div_rsp;

endpackage

### src/postfix_stack_calculator.sv
// ----------------------------------------------------------------------------
// postfix_stack_calculator
// Reverse-Polish integer evaluator: each token in gives one result out.
// ----------------------------------------------------------------------------
// A front end takes tokens into a two-entry queue, so input transfers keep
// going while the back end works or a result waits, until the queue fills.
// The back end runs one token at a time: push, unknown, finish and stack
// underflow end in the idle state; add and subtract pass an execute state,
// multiply also a product state (one multiplier, product registered), divide
// and remainder wait on the divider, which resolves one quotient bit per
// cycle. Stack depth is STACK_DEPTH entries; the top entry sits in a register
// and the rest in a single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
module postfix_stack_calculator
    import psc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [2:0]                i_action,
    input  logic signed [DATA_W-1:0]  i_operand,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0]                o_status,
    output logic signed [DATA_W-1:0]  o_value,
    output logic                      o_final_res,
    output logic [6:0]                o_depth_now
);

    t_tok      tok;
    logic      tok_valid;
    logic      tok_pop;
    t_div_req  div_req;
    t_div_rsp  div_rsp;

    psc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_operand   (i_operand),
        .o_tok       (tok),
        .o_tok_valid (tok_valid),
        .i_tok_pop   (tok_pop)
    );

    psc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    psc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (tok),
        .i_tok_valid (tok_valid),
        .o_tok_pop   (tok_pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_value     (o_value),
        .o_final_res (o_final_res),
        .o_depth_now (o_depth_now)
    );

endmodule

### src/psc_front.sv
// ----------------------------------------------------------------------------
// psc_front
// Accepts tokens, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module psc_front
    import psc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_action,
    input  logic [DATA_W-1:0]   i_operand,
    output t_tok                o_tok,
    output logic                o_tok_valid,
    input  logic                i_tok_pop
);

    t_tok              r_q [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, n_wp;
    logic [Q_AW-1:0]   r_rp, n_rp;
    logic [QC_W-1:0]   r_cnt, n_cnt;
    t_tok              cls_tok;
    t_action           act;
    logic              push_en;
    logic              pop_en;

    // Classify the incoming token
    always_comb begin
        act             = t_action'(i_action);
        cls_tok.op      = act;
        cls_tok.operand = i_operand;
        unique case (act)
            ACT_PUSH:    cls_tok.kind = K_PUSH;
            ACT_UNKNOWN: cls_tok.kind = K_UNKNOWN;
            ACT_FINISH:  cls_tok.kind = K_FINISH;
            default:     cls_tok.kind = K_ARITH;
        endcase
    end

    // Queue control
    assign o_stall     = (r_cnt == QC_W'(Q_DEPTH));
    assign o_tok_valid = (r_cnt != '0);
    assign push_en     = i_valid && !o_stall;
    assign pop_en      = i_tok_pop && o_tok_valid;
    assign o_tok       = r_q[r_rp];

    always_comb begin
        n_wp  = push_en ? r_wp + 1'b1 : r_wp;
        n_rp  = pop_en  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + QC_W'(push_en) - QC_W'(pop_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage, no reset
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_q[r_wp] <= cls_tok;
        end
    end

endmodule

### src/psc_div.sv
// ----------------------------------------------------------------------------
// psc_div
// Signed 32-bit truncating divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psc_div
    import psc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output t_div_rsp    o_rsp
);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIX  = 3'b100
    } t_dstate;

    t_dstate             r_state, n_state;
    logic [DIV_CW-1:0]   r_cnt, n_cnt;
    logic [DATA_W-1:0]   r_rem, n_rem;
    logic [DATA_W-1:0]   r_quo, n_quo;
    logic [DATA_W-1:0]   r_mb, n_mb;
    logic                r_neg_q, n_neg_q;
    logic                r_neg_r, n_neg_r;
    logic                r_want_rem, n_want_rem;
    logic                r_done, n_done;
    logic [DATA_W-1:0]   r_res, n_res;
    logic [DATA_W:0]     trial;
    logic [DATA_W:0]     diff;
    logic                a_neg, b_neg;

    assign a_neg = i_req.dividend[DATA_W-1];
    assign b_neg = i_req.divisor[DATA_W-1];
    assign trial = {r_rem, r_quo[DATA_W-1]};
    assign diff  = trial - {1'b0, r_mb};

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_mb       = r_mb;
        n_neg_q    = r_neg_q;
        n_neg_r    = r_neg_r;
        n_want_rem = r_want_rem;
        n_done     = 1'b0;
        n_res      = r_res;
        unique case (r_state)
            D_IDLE: begin
                if (i_req.start) begin
                    n_quo      = a_neg ? -i_req.dividend : i_req.dividend;
                    n_mb       = b_neg ? -i_req.divisor : i_req.divisor;
                    n_rem      = '0;
                    n_cnt      = '0;
                    n_neg_q    = a_neg ^ b_neg;
                    n_neg_r    = a_neg;
                    n_want_rem = i_req.want_rem;
                    n_state    = D_RUN;
                end
            end
            // restoring step: shift in next dividend bit, subtract if it fits
            D_RUN: begin
                if (!diff[DATA_W]) begin
                    n_rem = diff[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                    n_state = D_FIX;
                end
            end
            // restore signs: quotient by operand signs, remainder by dividend
            D_FIX: begin
                if (r_want_rem) begin
                    n_res = r_neg_r ? -r_rem : r_rem;
                end else begin
                    n_res = r_neg_q ? -r_quo : r_quo;
                end
                n_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_mb       <= n_mb;
        r_neg_q    <= n_neg_q;
        r_neg_r    <= n_neg_r;
        r_want_rem <= n_want_rem;
        r_res      <= n_res;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

### src/psc_back.sv
// ----------------------------------------------------------------------------
// psc_back
// Executes classified tokens against the stack and registers the result.
// The top of stack lives in a register; entries below it sit in memory.
// ----------------------------------------------------------------------------
module psc_back
    import psc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_tok                i_tok,
    input  logic                i_tok_valid,
    output logic                o_tok_pop,
    output t_div_req            o_div_req,
    input  t_div_rsp            i_div_rsp,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [DATA_W-1:0]   o_value,
    output logic                o_final_res,
    output logic [6:0]          o_depth_now
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_MUL  = 4'b0100,
        S_DIV  = 4'b1000
    } t_bstate;

    t_bstate                 r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [DATA_W-1:0]       r_top, n_top;
    t_action                 r_op, n_op;
    logic [DATA_W-1:0]       r_prod, n_prod;
    logic [DATA_W-1:0]       r_rd_data;
    logic [DATA_W-1:0]       mem [STACK_DEPTH];

    logic                    r_out_valid, n_out_valid;
    t_status                 r_out_status, n_out_status;
    logic [DATA_W-1:0]       r_out_value, n_out_value;
    logic                    r_out_final, n_out_final;
    logic [DEPTH_OUT_W-1:0]  r_out_depth, n_out_depth;

    logic                    out_free;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [ADDR_W-1:0]       mem_raddr;
    logic                    op_done;
    logic [DATA_W-1:0]       op_res;
    logic [CNT_W-1:0]        count_dec;
    logic [CNT_W-1:0]        count_inc;

    assign out_free  = !r_out_valid || !i_stall;
    assign count_dec = r_count - 1'b1;
    assign count_inc = r_count + 1'b1;
    assign mem_waddr = ADDR_W'(count_dec);
    assign mem_raddr = ADDR_W'(r_count - CNT_W'(2));

    // Main sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_top        = r_top;
        n_op         = r_op;
        n_prod       = r_prod;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_final  = r_out_final;
        n_out_depth  = r_out_depth;
        o_tok_pop    = 1'b0;
        mem_we       = 1'b0;
        op_done      = 1'b0;
        op_res       = r_prod;
        o_div_req.start    = 1'b0;
        o_div_req.want_rem = (r_op == ACT_REM);
        o_div_req.dividend = r_rd_data;
        o_div_req.divisor  = r_top;

        unique case (r_state)
            // take a token only when the output register is free
            S_IDLE: begin
                if (i_tok_valid && out_free) begin
                    o_tok_pop   = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_final = 1'b0;
                    n_out_value = '0;
                    unique case (i_tok.kind)
                        K_PUSH: begin
                            if (r_count == CNT_W'(STACK_DEPTH)) begin
                                n_out_status = ST_FULL;
                                n_out_depth  = DEPTH_OUT_W'(r_count);
                            end else begin
                                // old top spills into memory
                                mem_we       = (r_count != '0);
                                n_top        = i_tok.operand;
                                n_count      = count_inc;
                                n_out_status = ST_OK;
                                n_out_value  = i_tok.operand;
                                n_out_depth  = DEPTH_OUT_W'(count_inc);
                            end
                        end
                        K_UNKNOWN: begin
                            n_out_status = ST_UNKNOWN;
                            n_out_depth  = DEPTH_OUT_W'(r_count);
                        end
                        K_FINISH: begin
                            n_out_final = 1'b1;
                            n_out_depth = '0;
                            n_count     = '0;
                            if (r_count == '0) begin
                                n_out_status = ST_UNDERFLOW;
                            end else begin
                                n_out_status = ST_OK;
                                n_out_value  = r_top;
                            end
                        end
                        K_ARITH: begin
                            if (r_count < CNT_W'(2)) begin
                                n_count      = '0;
                                n_out_status = ST_UNDERFLOW;
                                n_out_depth  = '0;
                            end else begin
                                // left operand read from memory this cycle
                                n_out_valid = 1'b0;
                                n_op        = i_tok.op;
                                n_state     = S_EXEC;
                            end
                        end
                        default: n_out_valid = 1'b0;
                    endcase
                end
            end
            // left in r_rd_data, right in r_top
            S_EXEC: begin
                unique case (r_op)
                    ACT_ADD: begin
                        op_done = 1'b1;
                        op_res  = r_rd_data + r_top;
                    end
                    ACT_SUB: begin
                        op_done = 1'b1;
                        op_res  = r_rd_data - r_top;
                    end
                    ACT_MUL: begin
                        n_prod  = r_rd_data * r_top;
                        n_state = S_MUL;
                    end
                    ACT_REM, ACT_DIV: begin
                        if (r_top == '0) begin
                            n_count      = '0;
                            n_out_valid  = 1'b1;
                            n_out_status = ST_DIVZERO;
                            n_out_value  = '0;
                            n_out_final  = 1'b0;
                            n_out_depth  = '0;
                            n_state      = S_IDLE;
                        end else begin
                            o_div_req.start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_MUL: begin
                op_done = 1'b1;
                op_res  = r_prod;
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    op_done = 1'b1;
                    op_res  = i_div_rsp.result;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // two operands replaced by one result in the top register
        if (op_done) begin
            n_top        = op_res;
            n_count      = count_dec;
            n_out_valid  = 1'b1;
            n_out_status = ST_OK;
            n_out_value  = op_res;
            n_out_final  = 1'b0;
            n_out_depth  = DEPTH_OUT_W'(count_dec);
            n_state      = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_op         <= n_op;
        r_prod       <= n_prod;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_final  <= n_out_final;
        r_out_depth  <= n_out_depth;
    end

    // Stack memory below the top entry
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= r_top;
        end
        r_rd_data <= mem[mem_raddr];
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value     = r_out_value;
    assign o_final_res = r_out_final;
    assign o_depth_now = r_out_depth;

endmodule

### src/psc_checker.sv
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks for the postfix stack calculator, bound to the top.
// ----------------------------------------------------------------------------
module psc_checker
    import psc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_valid,
    input  logic                i_stall,
    input  logic [2:0]          o_status,
    input  logic [DATA_W-1:0]   o_value,
    input  logic                o_final_res,
    input  logic [6:0]          o_depth_now
);

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A held result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // Any error status carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_value == '0))
        else $error("nonzero value with error status");

    // Finish always leaves an empty stack
    a_fin_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_final_res |-> (o_depth_now == '0))
        else $error("stack not empty after finish");

    // Underflow always clears the stack
    a_uf_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_UNDERFLOW) |-> (o_depth_now == '0))
        else $error("stack not empty after underflow");

endmodule

bind postfix_stack_calculator psc_checker u_psc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_status    (o_status),
    .o_value     (o_value),
    .o_final_res (o_final_res),
    .o_depth_now (o_depth_now)
);
